>>> design/swirl_point_warp_macros.svh
// Assertion macros used by the port checker of the swirl point warp block.
`ifndef SWIRL_POINT_WARP_MACROS_SVH
`define SWIRL_POINT_WARP_MACROS_SVH

// Implication within the same cycle.
`define SWP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define SWP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/swp_pkg.sv
// Package with the types and constants of the swirl point warp block.
`default_nettype none

package swp_pkg;

    localparam int COORD_W     = 18;
    localparam int RADIUS_W    = 17;
    localparam int DELTA_W     = 19;
    localparam int D2_W        = 38;
    localparam int D2_KEEP_W   = 34;
    localparam int SQRT_IN_W   = 50;
    localparam int SQRT_STEPS  = 25;
    localparam int ROOT_W      = 25;
    localparam int DIV_STEPS   = 16;
    localparam int REM_W       = 33;
    localparam int RATIO_W     = 16;
    localparam int FALL_W      = 17;
    localparam int ANGLE_BITS  = 16;
    localparam int Z_W         = 17;
    localparam int SINE_W      = 31;
    localparam int TRIG_W      = 32;
    localparam int ROUND_W     = 22;
    localparam int TDATA_W     = 40;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TWIST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd4;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 3;

    // Items the block can hold: three front stages, the queue, 54 back stages.
    localparam int MAX_IN_FLIGHT = 61;
    localparam int FLIGHT_W      = 7;

    localparam logic [SINE_W-1:0] HORNER_INIT = 31'd172272;
    localparam logic [SINE_W-1:0] HORNER_C [0:3] = '{
        31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
    };
    localparam logic [SINE_W-1:0] ONE_Q30 = 31'h4000_0000;

    localparam logic signed [COORD_W:0] COORD_MAX = 19'sd131071;
    localparam logic signed [COORD_W:0] COORD_MIN = -19'sd131072;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic [RADIUS_W-1:0]       radius;
        logic                      twist_negative;
        logic                      enable;
    } swp_cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic [D2_KEEP_W-1:0]      d2;
        logic                      in_zone;
        logic                      last;
    } swp_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic                      in_zone;
        logic                      last;
    } swp_meta_t;

    typedef struct packed {
        logic full;
        logic empty;
    } swp_fifo_stat_t;

endpackage

`default_nettype wire

>>> design/swp_front.sv
// Front part: takes points, forms the offset from the centre and classifies them.
`default_nettype none

module swp_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  swp_pkg::swp_cfg_t                       cfg,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [swp_pkg::COORD_W-1:0]      in_x,
    input  logic signed [swp_pkg::COORD_W-1:0]      in_y,
    input  logic                                    in_last,
    input  swp_pkg::swp_fifo_stat_t                 fifo_stat,
    output logic                                    push,
    output swp_pkg::swp_item_t                      push_item
);
    import swp_pkg::*;

    logic                      a_valid_reg;
    logic signed [COORD_W-1:0] a_px_reg, a_py_reg;
    logic signed [DELTA_W-1:0] a_dx_reg, a_dy_reg;
    logic                      a_last_reg;

    logic                      b_valid_reg;
    logic signed [COORD_W-1:0] b_px_reg, b_py_reg;
    logic signed [DELTA_W-1:0] b_dx_reg, b_dy_reg;
    logic                      b_last_reg;
    logic [D2_W-1:0]           b_sqx_reg, b_sqy_reg;
    logic [2*RADIUS_W-1:0]     b_r2_reg;

    logic                      c_valid_reg;
    swp_item_t                 c_item_reg;

    logic                      advance;
    logic signed [DELTA_W-1:0] dx_next, dy_next;
    logic signed [D2_W-1:0]    sqx_next, sqy_next;
    logic [2*RADIUS_W-1:0]     r2_next;
    logic [D2_W-1:0]           d2_sum;
    swp_item_t                 item_next;

    assign advance  = !c_valid_reg || !fifo_stat.full;
    assign in_ready = advance;
    assign push     = c_valid_reg && !fifo_stat.full;
    assign push_item = c_item_reg;

    always_comb
    begin
        dx_next  = {in_x[COORD_W-1], in_x} - {cfg.center_x[COORD_W-1], cfg.center_x};
        dy_next  = {in_y[COORD_W-1], in_y} - {cfg.center_y[COORD_W-1], cfg.center_y};
        sqx_next = a_dx_reg * a_dx_reg;
        sqy_next = a_dy_reg * a_dy_reg;
        r2_next  = cfg.radius * cfg.radius;
        d2_sum   = b_sqx_reg + b_sqy_reg;
        item_next.px     = b_px_reg;
        item_next.py     = b_py_reg;
        item_next.dx     = b_dx_reg;
        item_next.dy     = b_dy_reg;
        item_next.d2     = d2_sum[D2_KEEP_W-1:0];
        item_next.last   = b_last_reg;
        item_next.in_zone = cfg.enable && (cfg.radius != '0)
                            && (d2_sum < {{(D2_W-2*RADIUS_W){1'b0}}, b_r2_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_px_reg   <= in_x;
            a_py_reg   <= in_y;
            a_dx_reg   <= dx_next;
            a_dy_reg   <= dy_next;
            a_last_reg <= in_last;
            b_px_reg   <= a_px_reg;
            b_py_reg   <= a_py_reg;
            b_dx_reg   <= a_dx_reg;
            b_dy_reg   <= a_dy_reg;
            b_last_reg <= a_last_reg;
            b_sqx_reg  <= sqx_next;
            b_sqy_reg  <= sqy_next;
            b_r2_reg   <= r2_next;
            c_item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

>>> design/swp_fifo.sv
// Short queue of classified points between the front and the back part.
`default_nettype none

module swp_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  swp_pkg::swp_item_t          push_item,
    input  logic                        pop,
    output swp_pkg::swp_item_t          pop_item,
    output swp_pkg::swp_fifo_stat_t     stat
);
    import swp_pkg::*;

    swp_item_t             mem_reg [0:FIFO_DEPTH-1];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

>>> design/swp_qsine.sv
// Pipelined quarter-wave sine by an odd Horner polynomial, six stages.
`default_nettype none

module swp_qsine (
    input  logic                            clk,
    input  logic                            en,
    input  logic [swp_pkg::Z_W-1:0]         z,
    output logic [swp_pkg::SINE_W-1:0]      y
);
    import swp_pkg::*;

    logic [Z_W-1:0]    z_reg  [0:4];
    logic [SINE_W-1:0] z2_reg [0:3];
    logic [SINE_W-1:0] h_reg  [0:3];
    logic [SINE_W-1:0] y_reg;

    logic [2*Z_W-1:0]    zz;
    logic [SINE_W-1:0]   h_src  [0:3];
    logic [SINE_W-1:0]   h_next [0:3];
    logic [2*SINE_W-1:0] prod;
    logic [TRIG_W-1:0]   diff;
    logic [Z_W+SINE_W-1:0] fin;
    logic [TRIG_W-1:0]   fin_shift;

    assign y = y_reg;

    always_comb
    begin
        zz = z * z;
        h_src[0] = HORNER_INIT;
        for (int k = 1; k < 4; k++)
            h_src[k] = h_reg[k-1];
        for (int k = 0; k < 4; k++)
        begin
            prod      = z2_reg[k] * h_src[k];
            diff      = {1'b0, HORNER_C[k]} - prod[2*SINE_W-1:30];
            h_next[k] = diff[SINE_W-1:0];
        end
        fin       = z_reg[4] * h_reg[3];
        fin_shift = fin[Z_W+SINE_W-1:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0]  <= z;
            z2_reg[0] <= zz[SINE_W+1:2];
            for (int k = 1; k < 5; k++)
                z_reg[k] <= z_reg[k-1];
            for (int k = 1; k < 4; k++)
                z2_reg[k] <= z2_reg[k-1];
            for (int k = 0; k < 4; k++)
                h_reg[k] <= h_next[k];
            if (fin_shift > {1'b0, ONE_Q30})
                y_reg <= ONE_Q30;
            else
                y_reg <= fin_shift[SINE_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> design/swp_back.sv
// Back part: root, ratio, smoothstep falloff, sine and cosine and the rotation.
`default_nettype none

module swp_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  swp_pkg::swp_cfg_t                   cfg,
    input  swp_pkg::swp_fifo_stat_t             fifo_stat,
    input  swp_pkg::swp_item_t                  pop_item,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [swp_pkg::COORD_W-1:0]  out_x,
    output logic signed [swp_pkg::COORD_W-1:0]  out_y,
    output logic                                out_last,
    output logic                                out_rotated
);
    import swp_pkg::*;

    localparam int META_LEN = 53;
    localparam int ST_PROD  = 51;
    localparam int ST_ROUND = 52;

    logic      ben;
    logic      vld_reg  [0:META_LEN-1];
    swp_meta_t meta_reg [0:META_LEN-1];
    logic      out_valid_reg;

    logic [SQRT_IN_W-1:0] sq_v_reg   [0:SQRT_STEPS];
    logic [SQRT_IN_W-1:0] sq_res_reg [0:SQRT_STEPS];
    logic [SQRT_IN_W-1:0] sq_v_next   [1:SQRT_STEPS];
    logic [SQRT_IN_W-1:0] sq_res_next [1:SQRT_STEPS];
    logic [SQRT_IN_W:0]   sq_trial;
    logic [SQRT_IN_W:0]   sq_bit;

    logic [REM_W-1:0]   div_rem_reg  [0:DIV_STEPS-1];
    logic [RATIO_W-1:0] div_q_reg    [0:DIV_STEPS-1];
    logic [REM_W-1:0]   div_rem_src  [0:DIV_STEPS-1];
    logic [RATIO_W-1:0] div_q_src    [0:DIV_STEPS-1];
    logic [REM_W-1:0]   div_rem_next [0:DIV_STEPS-1];
    logic [RATIO_W-1:0] div_q_next   [0:DIV_STEPS-1];
    logic [REM_W-1:0]   div_sh;

    logic [RATIO_W-1:0]   t_reg, t2_reg;
    logic [2*RATIO_W-1:0] tt;
    logic [FALL_W-1:0]    f_reg;
    logic [FALL_W:0]      poly;
    logic [RATIO_W+FALL_W:0] s_prod;
    logic [FALL_W:0]      f_wide;

    logic [FALL_W+2+ANGLE_BITS-1:0] ph_wide;
    logic [FALL_W+1:0]              f3;
    logic [ANGLE_BITS-1:0]          phase;
    logic [TRIG_W-1:0]              turn;
    logic [Z_W-1:0]                 zs_reg, zc_reg;
    logic [1:0]                     quad_reg [0:6];
    logic [Z_W-1:0]                 zs_next;

    logic [SINE_W-1:0] sine_s, sine_c;
    logic signed [TRIG_W-1:0] sn, cs, s_pos, c_pos;

    localparam int PROD_W = DELTA_W + TRIG_W;
    logic signed [PROD_W-1:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic signed [PROD_W:0]   sum_x, sum_y;
    logic signed [ROUND_W-1:0] rx_reg, ry_reg;

    logic signed [COORD_W+4:0] ox_full, oy_full;
    logic signed [COORD_W-1:0] ox_sat, oy_sat;
    logic signed [COORD_W-1:0] out_x_reg, out_y_reg;
    logic                      out_last_reg, out_rot_reg;

    assign ben = !out_valid_reg || out_ready;
    assign pop = ben && !fifo_stat.empty;

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_last    = out_last_reg;
    assign out_rotated = out_rot_reg;

    // Digit-by-digit square root, one result bit per stage.
    always_comb
    begin
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            sq_bit   = (SQRT_IN_W+1)'(1) << (2*(SQRT_STEPS-1-k));
            sq_trial = {1'b0, sq_res_reg[k]} + sq_bit;
            if ({1'b0, sq_v_reg[k]} >= sq_trial)
            begin
                sq_v_next[k+1]   = SQRT_IN_W'({1'b0, sq_v_reg[k]} - sq_trial);
                sq_res_next[k+1] = (sq_res_reg[k] >> 1) | sq_bit[SQRT_IN_W-1:0];
            end
            else
            begin
                sq_v_next[k+1]   = sq_v_reg[k];
                sq_res_next[k+1] = sq_res_reg[k] >> 1;
            end
        end
    end

    // Restoring division of the scaled distance by the radius.
    always_comb
    begin
        div_rem_src[0] = {sq_res_reg[SQRT_STEPS][ROOT_W-1:0], 8'd0};
        div_q_src[0]   = '0;
        for (int j = 1; j < DIV_STEPS; j++)
        begin
            div_rem_src[j] = div_rem_reg[j-1];
            div_q_src[j]   = div_q_reg[j-1];
        end
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            div_sh = REM_W'(cfg.radius) << (DIV_STEPS-1-j);
            div_q_next[j] = div_q_src[j];
            if (div_rem_src[j] >= div_sh)
            begin
                div_rem_next[j] = div_rem_src[j] - div_sh;
                div_q_next[j][DIV_STEPS-1-j] = 1'b1;
            end
            else
            begin
                div_rem_next[j] = div_rem_src[j];
            end
        end
    end

    always_comb
    begin
        tt     = div_q_reg[DIV_STEPS-1] * div_q_reg[DIV_STEPS-1];
        poly   = (FALL_W+1)'(3 * 65536) - {1'b0, t_reg, 1'b0};
        s_prod = t2_reg * poly;
        f_wide = (FALL_W+1)'(65536) - s_prod[RATIO_W+FALL_W:16];
        f3     = (FALL_W+2)'(f_reg) * (FALL_W+2)'(3);
        ph_wide = {f3, {ANGLE_BITS{1'b0}}};
        phase  = ph_wide[16 +: ANGLE_BITS];
        if (cfg.twist_negative)
            phase = -phase;
        turn    = {phase, {(TRIG_W-ANGLE_BITS){1'b0}}};
        zs_next = {1'b0, turn[29:14]};
    end

    swp_qsine u_sine (
        .clk (clk),
        .en  (ben),
        .z   (zs_reg),
        .y   (sine_s)
    );

    swp_qsine u_cosine (
        .clk (clk),
        .en  (ben),
        .z   (zc_reg),
        .y   (sine_c)
    );

    always_comb
    begin
        s_pos = TRIG_W'(sine_s);
        c_pos = TRIG_W'(sine_c);
        case (quad_reg[6])
            2'd0:
            begin
                sn = s_pos;
                cs = c_pos;
            end
            2'd1:
            begin
                sn = c_pos;
                cs = -s_pos;
            end
            2'd2:
            begin
                sn = -s_pos;
                cs = -c_pos;
            end
            default:
            begin
                sn = -c_pos;
                cs = s_pos;
            end
        endcase
        sum_x = (PROD_W+1)'(pxc_reg) - (PROD_W+1)'(pys_reg) + (PROD_W+1)'(64'sd536870912);
        sum_y = (PROD_W+1)'(pxs_reg) + (PROD_W+1)'(pyc_reg) + (PROD_W+1)'(64'sd536870912);
        ox_full = (COORD_W+5)'(cfg.center_x) + (COORD_W+5)'(rx_reg);
        oy_full = (COORD_W+5)'(cfg.center_y) + (COORD_W+5)'(ry_reg);
        if (ox_full > (COORD_W+5)'(COORD_MAX))
            ox_sat = COORD_MAX[COORD_W-1:0];
        else if (ox_full < (COORD_W+5)'(COORD_MIN))
            ox_sat = COORD_MIN[COORD_W-1:0];
        else
            ox_sat = ox_full[COORD_W-1:0];
        if (oy_full > (COORD_W+5)'(COORD_MAX))
            oy_sat = COORD_MAX[COORD_W-1:0];
        else if (oy_full < (COORD_W+5)'(COORD_MIN))
            oy_sat = COORD_MIN[COORD_W-1:0];
        else
            oy_sat = oy_full[COORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < META_LEN; k++)
                vld_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ben)
        begin
            vld_reg[0] <= !fifo_stat.empty;
            for (int k = 1; k < META_LEN; k++)
                vld_reg[k] <= vld_reg[k-1];
            out_valid_reg <= vld_reg[META_LEN-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ben)
        begin
            meta_reg[0].px      <= pop_item.px;
            meta_reg[0].py      <= pop_item.py;
            meta_reg[0].dx      <= pop_item.dx;
            meta_reg[0].dy      <= pop_item.dy;
            meta_reg[0].in_zone <= pop_item.in_zone;
            meta_reg[0].last    <= pop_item.last;
            for (int k = 1; k < META_LEN; k++)
                meta_reg[k] <= meta_reg[k-1];

            sq_v_reg[0]   <= {pop_item.d2, 16'd0};
            sq_res_reg[0] <= '0;
            for (int k = 1; k <= SQRT_STEPS; k++)
            begin
                sq_v_reg[k]   <= sq_v_next[k];
                sq_res_reg[k] <= sq_res_next[k];
            end

            for (int j = 0; j < DIV_STEPS; j++)
            begin
                div_rem_reg[j] <= div_rem_next[j];
                div_q_reg[j]   <= div_q_next[j];
            end

            t_reg  <= div_q_reg[DIV_STEPS-1];
            t2_reg <= tt[2*RATIO_W-1:RATIO_W];
            f_reg  <= f_wide[FALL_W-1:0];

            zs_reg      <= zs_next;
            zc_reg      <= Z_W'(65536) - zs_next;
            quad_reg[0] <= turn[31:30];
            for (int k = 1; k < 7; k++)
                quad_reg[k] <= quad_reg[k-1];

            pxc_reg <= meta_reg[ST_PROD-1].dx * cs;
            pys_reg <= meta_reg[ST_PROD-1].dy * sn;
            pxs_reg <= meta_reg[ST_PROD-1].dx * sn;
            pyc_reg <= meta_reg[ST_PROD-1].dy * cs;

            rx_reg <= sum_x[PROD_W:30];
            ry_reg <= sum_y[PROD_W:30];

            out_last_reg <= meta_reg[ST_ROUND].last;
            out_rot_reg  <= meta_reg[ST_ROUND].in_zone;
            if (meta_reg[ST_ROUND].in_zone)
            begin
                out_x_reg <= ox_sat;
                out_y_reg <= oy_sat;
            end
            else
            begin
                out_x_reg <= meta_reg[ST_ROUND].px;
                out_y_reg <= meta_reg[ST_ROUND].py;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/swirl_point_warp.sv
// Top level of the swirl point warp block.
`default_nettype none

// Warps a stream of points with one swirl vortex. One point is taken in every
// clock while the output side keeps up. The back pipeline holds a 25-stage
// square root and a 16-stage divider; a four-entry queue sits between the
// classifying front and the back. Points outside the radius, or with the
// vortex disabled, leave unchanged with the flag clear.
module swirl_point_warp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [swp_pkg::TDATA_W-1:0]         s_tdata,  // in_x, in_y, zero pad
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [swp_pkg::TDATA_W-1:0]         m_tdata,  // out_x, out_y, zero pad
    output logic                                m_tlast,
    output logic                                m_tuser,  // was_rotated
    input  logic                                cfg_we,
    input  logic [swp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [swp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import swp_pkg::*;

    swp_cfg_t       cfg_reg;
    swp_fifo_stat_t fifo_stat;
    swp_item_t      push_item, pop_item;
    logic           push, pop;
    logic signed [COORD_W-1:0] out_x, out_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER_X: cfg_reg.center_x       <= cfg_data[COORD_W-1:0];
                CFG_CENTER_Y: cfg_reg.center_y       <= cfg_data[COORD_W-1:0];
                CFG_RADIUS:   cfg_reg.radius         <= cfg_data[RADIUS_W-1:0];
                CFG_TWIST:    cfg_reg.twist_negative <= cfg_data[0];
                CFG_ENABLE:   cfg_reg.enable         <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    swp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (s_tdata[COORD_W-1:0]),
        .in_y      (s_tdata[2*COORD_W-1:COORD_W]),
        .in_last   (s_tlast),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_item (push_item)
    );

    swp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (fifo_stat)
    );

    swp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .fifo_stat   (fifo_stat),
        .pop_item    (pop_item),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_last    (m_tlast),
        .out_rotated (m_tuser)
    );

    assign m_tdata = {{(TDATA_W-2*COORD_W){1'b0}}, out_y, out_x};

endmodule

`default_nettype wire

>>> design/swp_checker.sv
// Port checker for the swirl point warp block, bound to the top level.
`default_nettype none

`include "swirl_point_warp_macros.svh"

module swp_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [swp_pkg::TDATA_W-1:0]         m_tdata,
    input  logic                                m_tlast,
    input  logic                                m_tuser
);
    import swp_pkg::*;

    logic [FLIGHT_W-1:0] count_reg, count_next;
    logic                in_xfer, out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_comb
    begin
        count_next = count_reg;
        if (in_xfer && !out_xfer)
            count_next = count_reg + 1'b1;
        else if (out_xfer && !in_xfer)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    `SWP_ASSERT_NOW(a_no_invented_result, m_tvalid, count_reg != '0, "result without a pending point")
    `SWP_ASSERT_NOW(a_flight_bound, 1'b1, count_reg <= FLIGHT_W'(MAX_IN_FLIGHT), "too many points in flight")
    `SWP_ASSERT_NEXT(a_valid_held, m_tvalid && !m_tready, m_tvalid, "output valid dropped while stalled")
    `SWP_ASSERT_NEXT(a_data_held, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output changed while stalled")

endmodule

bind swirl_point_warp swp_checker u_swp_checker (.*);

`default_nettype wire
